/* hw/rtl/fsnp_pkg.sv */
// ---------------------------------------------------------------------------
// fsnp_pkg
// Shared types and character codes for the format-string number printer.
// ---------------------------------------------------------------------------
package fsnp_pkg;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_PCT    = 8'h25;  // '%'
  localparam logic [7:0] CH_ZERO   = 8'h30;  // '0'
  localparam logic [7:0] CH_UPPA   = 8'h41;  // 'A'
  localparam logic [7:0] CH_LPAREN = 8'h28;  // '('
  localparam logic [7:0] CH_RPAREN = 8'h29;  // ')'
  localparam logic [7:0] CH_LOW_X  = 8'h78;  // 'x'
  localparam logic [7:0] CH_UPP_X  = 8'h58;  // 'X'
  localparam logic [7:0] CH_LOW_D  = 8'h64;  // 'd'
  localparam logic [7:0] CH_LOW_I  = 8'h69;  // 'i'
  localparam logic [7:0] CH_LOW_U  = 8'h75;  // 'u'
  localparam logic [7:0] CH_UPP_U  = 8'h55;  // 'U'

  localparam int unsigned DEC_DIGITS = 10;
  localparam int unsigned HEX_DIGITS = 8;
  localparam int unsigned VAL_W      = 32;
  localparam int unsigned BCD_W      = 4 * DEC_DIGITS;

  // decoration position inside "(0x"
  localparam logic [1:0] DECO_PAREN = 2'd0;
  localparam logic [1:0] DECO_ZERO  = 2'd1;
  localparam logic [1:0] DECO_X     = 2'd2;

  typedef struct packed {
    logic start;  // load a new binary value and begin conversion
    logic shift;  // drop the top BCD digit
  } bcd_ctrl_t;

  typedef struct packed {
    logic       busy;
    logic [3:0] digit;  // current top BCD digit
  } bcd_stat_t;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_LIT   = 7'b0000010,
    S_CONV  = 7'b0000100,
    S_DEC   = 7'b0001000,
    S_DECO  = 7'b0010000,
    S_HEX   = 7'b0100000,
    S_CLOSE = 7'b1000000
  } state_t;

  function automatic logic [7:0] hex_ascii(input logic [3:0] d);
    logic [7:0] r;
    if (d > 4'd9) begin
      r = CH_UPPA + {4'h0, d} - 8'd10;
    end else begin
      r = CH_ZERO + {4'h0, d};
    end
    return r;
  endfunction

endpackage

/* hw/rtl/fsnp_bcd.sv */
// ---------------------------------------------------------------------------
// fsnp_bcd
// Bit-serial binary to BCD converter (shift and add three), one bit a cycle.
// ---------------------------------------------------------------------------
module fsnp_bcd
  import fsnp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  bcd_ctrl_t        ctrl,
  input  logic [VAL_W-1:0] bin_in,
  output bcd_stat_t        stat
);

  logic [VAL_W-1:0] bin_r, bin_nxt;
  logic [BCD_W-1:0] bcd_r, bcd_nxt;
  logic [BCD_W-1:0] adj;
  logic [4:0]       cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;

  // add three to every digit of five or more
  always_comb begin
    for (int i = 0; i < DEC_DIGITS; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_r[4*i +: 4];
      end
    end
  end

  always_comb begin
    bin_nxt  = bin_r;
    bcd_nxt  = bcd_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (ctrl.start) begin
      bin_nxt  = bin_in;
      bcd_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      bcd_nxt = {adj[BCD_W-2:0], bin_r[VAL_W-1]};
      bin_nxt = {bin_r[VAL_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
      end
    end else if (ctrl.shift) begin
      bcd_nxt = {bcd_r[BCD_W-5:0], 4'h0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign stat.busy  = busy_r;
  assign stat.digit = bcd_r[BCD_W-1 -: 4];

endmodule

/* hw/rtl/format_string_number_printer.sv */
// Format-string number printer.
// A literal word passes through S_LIT before it reaches the output register;
//   a decimal conversion first goes through the bit-serial BCD converter.
// Only one word is in flight: a new format character is taken only once the
//   last one is finished.
// Reset (rst_n low, synchronous): idle, pending '%' cleared, output empty.
// ---------------------------------------------------------------------------
// format_string_number_printer
// Copies literal characters and expands %x, %X, %d, %i, %u and %U conversions.
// ---------------------------------------------------------------------------
module format_string_number_printer
  import fsnp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_fmt_char,
  input  logic [VAL_W-1:0] in_value,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_char,
  output logic             out_number_port,
  output logic             out_last_char
);

  state_t           state_r, state_nxt;
  logic             pending_r, pending_nxt;
  logic [7:0]       char_r, char_nxt;
  logic             mode_u_r, mode_u_nxt;
  logic [3:0]       idx_r, idx_nxt;
  logic             seen_r, seen_nxt;
  logic [1:0]       deco_r, deco_nxt;
  logic [VAL_W-1:0] hex_sr_r, hex_sr_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_char_r, out_char_nxt;
  logic             out_num_r, out_num_nxt;
  logic             out_last_r, out_last_nxt;

  bcd_ctrl_t        bcd_ctrl;
  bcd_stat_t        bcd_stat;

  logic             slot_free;
  logic [3:0]       hex_dig;
  logic             show;
  logic             last_pos;

  fsnp_bcd u_bcd (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (bcd_ctrl),
    .bin_in (in_value),
    .stat   (bcd_stat)
  );

  // output register is free when empty or being drained this cycle
  assign slot_free = !out_valid_r || out_ready;
  assign hex_dig   = hex_sr_r[VAL_W-1 -: 4];

  always_comb begin
    state_nxt     = state_r;
    pending_nxt   = pending_r;
    char_nxt      = char_r;
    mode_u_nxt    = mode_u_r;
    idx_nxt       = idx_r;
    seen_nxt      = seen_r;
    deco_nxt      = deco_r;
    hex_sr_nxt    = hex_sr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_char_nxt  = out_char_r;
    out_num_nxt   = out_num_r;
    out_last_nxt  = out_last_r;
    bcd_ctrl      = '0;
    show          = 1'b0;
    last_pos      = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          char_nxt   = in_fmt_char;
          hex_sr_nxt = in_value;
          idx_nxt    = '0;
          seen_nxt   = 1'b0;
          deco_nxt   = DECO_PAREN;
          if (in_fmt_char == CH_NUL) begin
            // end of string: drop any armed '%'
            pending_nxt = 1'b0;
          end else if (pending_r) begin
            pending_nxt = 1'b0;
            if (in_fmt_char == CH_LOW_X || in_fmt_char == CH_UPP_X) begin
              mode_u_nxt = 1'b0;
              state_nxt  = S_HEX;
            end else if (in_fmt_char == CH_LOW_D || in_fmt_char == CH_LOW_I ||
                         in_fmt_char == CH_LOW_U) begin
              mode_u_nxt     = 1'b0;
              bcd_ctrl.start = 1'b1;
              state_nxt      = S_CONV;
            end else if (in_fmt_char == CH_UPP_U) begin
              mode_u_nxt     = 1'b1;
              bcd_ctrl.start = 1'b1;
              state_nxt      = S_CONV;
            end
            // any other specifier is swallowed
          end else if (in_fmt_char == CH_PCT) begin
            pending_nxt = 1'b1;
          end else begin
            state_nxt = S_LIT;
          end
        end
      end

      S_LIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = char_r;
          out_num_nxt   = 1'b0;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      S_CONV: begin
        // hold until the converter has taken in all 32 bits
        if (!bcd_stat.busy) begin
          state_nxt = S_DEC;
        end
      end

      S_DEC: begin
        last_pos = (idx_r == 4'(DEC_DIGITS - 1));
        show     = (bcd_stat.digit != 4'h0) || seen_r || last_pos;
        // leading zeros advance without waiting for the output
        if (!show || slot_free) begin
          if (show) begin
            out_valid_nxt = 1'b1;
            out_char_nxt  = CH_ZERO + {4'h0, bcd_stat.digit};
            out_num_nxt   = 1'b1;
            out_last_nxt  = last_pos && !mode_u_r;
          end
          seen_nxt       = seen_r || show;
          bcd_ctrl.shift = 1'b1;
          idx_nxt        = idx_r + 4'd1;
          if (last_pos) begin
            idx_nxt   = '0;
            seen_nxt  = 1'b0;
            state_nxt = mode_u_r ? S_DECO : S_IDLE;
          end
        end
      end

      S_DECO: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_num_nxt   = 1'b1;
          out_last_nxt  = 1'b0;
          deco_nxt      = deco_r + 2'd1;
          case (deco_r)
            DECO_PAREN: out_char_nxt = CH_LPAREN;
            DECO_ZERO:  out_char_nxt = CH_ZERO;
            DECO_X:     out_char_nxt = CH_LOW_X;
            default:    out_char_nxt = CH_LOW_X;
          endcase
          if (deco_r == DECO_X) begin
            state_nxt = S_HEX;
          end
        end
      end

      S_HEX: begin
        last_pos = (idx_r == 4'(HEX_DIGITS - 1));
        show     = (hex_dig != 4'h0) || seen_r || last_pos;
        if (!show || slot_free) begin
          if (show) begin
            out_valid_nxt = 1'b1;
            out_char_nxt  = hex_ascii(hex_dig);
            out_num_nxt   = 1'b1;
            out_last_nxt  = last_pos && !mode_u_r;
          end
          seen_nxt   = seen_r || show;
          hex_sr_nxt = {hex_sr_r[VAL_W-5:0], 4'h0};
          idx_nxt    = idx_r + 4'd1;
          if (last_pos) begin
            idx_nxt   = '0;
            seen_nxt  = 1'b0;
            state_nxt = mode_u_r ? S_CLOSE : S_IDLE;
          end
        end
      end

      S_CLOSE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CH_RPAREN;
          out_num_nxt   = 1'b1;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pending_r   <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      seen_r      <= 1'b0;
      deco_r      <= DECO_PAREN;
      mode_u_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pending_r   <= pending_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
      seen_r      <= seen_nxt;
      deco_r      <= deco_nxt;
      mode_u_r    <= mode_u_nxt;
    end
    char_r     <= char_nxt;
    hex_sr_r   <= hex_sr_nxt;
    out_char_r <= out_char_nxt;
    out_num_r  <= out_num_nxt;
    out_last_r <= out_last_nxt;
  end

  // one word in flight at a time
  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_char        = out_char_r;
  assign out_number_port = out_num_r;
  assign out_last_char   = out_last_r;

endmodule
